// File: src/tlb_translate_fifo_lru_core_defines.svh
// Assertion macros shared by the TLB RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef TLB_TRANSLATE_FIFO_LRU_CORE_DEFINES_SVH
`define TLB_TRANSLATE_FIFO_LRU_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLBFL_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLBFL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/tlbfl_pkg.sv
// Shared types, constants and helper functions for the fully associative TLB.
// Depends on nothing; used by every module of the block.
`default_nettype none

package tlbfl_pkg;

    // Field widths fixed by the interface.
    localparam int ADDRESS_BITS      = 32;
    localparam int FRAME_BITS        = 20;
    localparam int PA_BITS           = 36;
    localparam int STAMP_BITS        = 32;
    localparam int MIN_SHIFT         = 4;
    localparam int MAX_SHIFT         = 16;
    localparam int PAGE_BITS         = ADDRESS_BITS - MIN_SHIFT;
    localparam int SHIFT_BITS        = 5;
    localparam int ENTRIES_BITS      = 5;
    localparam int CFG_DATA_BITS     = 5;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int TLB_DEPTH_DEFAULT = 16;

    // Operation codes.
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_FILL      = 2'd1;
    localparam logic [1:0] OP_FLUSH     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAGE_SIZE_LOG2   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPLACEMENT_MODE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TLB_ENTRIES      = 2'd2;

    // Replacement modes and configuration reset values.
    localparam logic                    MODE_FIFO           = 1'b0;
    localparam logic                    MODE_LRU            = 1'b1;
    localparam logic [SHIFT_BITS-1:0]   PAGE_SIZE_LOG2_RST  = 5'd6;
    localparam logic [ENTRIES_BITS-1:0] TLB_ENTRIES_RST     = 5'd4;

    // Input word.
    typedef struct packed {
        logic [1:0]              op;
        logic [ADDRESS_BITS-1:0] logical_address;
        logic [FRAME_BITS-1:0]   frame;
    } req_t;

    // Result word.
    typedef struct packed {
        logic               hit;
        logic [PA_BITS-1:0] physical_address;
        logic               replaced;
    } res_t;

    // Configuration registers.
    typedef struct packed {
        logic [SHIFT_BITS-1:0]   page_size_log2;
        logic                    replacement_mode;
        logic [ENTRIES_BITS-1:0] tlb_entries;
    } cfg_t;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                  flush;
        logic                  purge;
        logic                  touch;
        logic                  insert;
        logic                  evict;
        logic                  lru;
        logic [STAMP_BITS-1:0] stamp;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
    } cmd_t;

    // Status returned by each cell.
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic [FRAME_BITS-1:0] frame;
    } stat_t;

    // Victim candidate travelling along the cell chain.
    typedef struct packed {
        logic                  found;
        logic [STAMP_BITS-1:0] age;
        logic [STAMP_BITS-1:0] fill_age;
    } cand_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COUNT,
        ST_SWEEP,
        ST_EVICT,
        ST_INSERT
    } state_t;

    // Page size exponent limited to the supported range.
    function automatic logic [SHIFT_BITS-1:0] sat_shift(input logic [SHIFT_BITS-1:0] raw);
        logic [SHIFT_BITS-1:0] sh;
        if (raw < SHIFT_BITS'(MIN_SHIFT)) begin
            sh = SHIFT_BITS'(MIN_SHIFT);
        end else if (raw > SHIFT_BITS'(MAX_SHIFT)) begin
            sh = SHIFT_BITS'(MAX_SHIFT);
        end else begin
            sh = raw;
        end
        return sh;
    endfunction

    // Page number of a logical address.
    function automatic logic [PAGE_BITS-1:0] page_of(input logic [ADDRESS_BITS-1:0] addr,
                                                     input logic [SHIFT_BITS-1:0] sh);
        logic [ADDRESS_BITS-1:0] shifted;
        shifted = addr >> sh;
        return shifted[PAGE_BITS-1:0];
    endfunction

    // Frame shifted into place with the page offset below it.
    function automatic logic [PA_BITS-1:0] phys_addr(input logic [FRAME_BITS-1:0] frame,
                                                     input logic [ADDRESS_BITS-1:0] addr,
                                                     input logic [SHIFT_BITS-1:0] sh);
        logic [PA_BITS-1:0] mask;
        mask = (PA_BITS'(1) << sh) - PA_BITS'(1);
        return (PA_BITS'(frame) << sh) | (PA_BITS'(addr) & mask);
    endfunction

endpackage

`default_nettype wire

// File: src/tlbfl_cell.sv
// One TLB entry plus one stage of the victim search chain.
// Depends on tlbfl_pkg.
`default_nettype none

module tlbfl_cell #(
    parameter int  TLB_DEPTH  = tlbfl_pkg::TLB_DEPTH_DEFAULT,
    parameter int  CELL_INDEX = 0,
    localparam int IDX_W      = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  tlbfl_pkg::cmd_t           cmd,
    input  wire  [IDX_W-1:0]          insert_idx,
    input  wire  [IDX_W-1:0]          victim_idx,
    input  tlbfl_pkg::cand_t          cand_in,
    input  wire  [IDX_W-1:0]          cand_idx_in,
    output tlbfl_pkg::cand_t          cand_out,
    output logic [IDX_W-1:0]          cand_idx_out,
    output tlbfl_pkg::stat_t          stat
);

    logic                                 valid_reg, valid_next;
    logic [tlbfl_pkg::PAGE_BITS-1:0]      page_reg, page_next;
    logic [tlbfl_pkg::FRAME_BITS-1:0]     frame_reg, frame_next;
    logic [tlbfl_pkg::STAMP_BITS-1:0]     fill_stamp_reg, fill_stamp_next;
    logic [tlbfl_pkg::STAMP_BITS-1:0]     use_stamp_reg, use_stamp_next;
    tlbfl_pkg::cand_t                     cand_reg, cand_next;
    logic [IDX_W-1:0]                     cand_idx_reg, cand_idx_next;

    logic [IDX_W-1:0]                     my_idx;
    logic                                 page_match;
    logic                                 frame_match;
    logic                                 insert_here;
    logic                                 evict_here;
    logic [tlbfl_pkg::STAMP_BITS-1:0]     use_age;
    logic [tlbfl_pkg::STAMP_BITS-1:0]     fill_age;
    logic [tlbfl_pkg::STAMP_BITS-1:0]     age;
    logic                                 take_self;

    assign my_idx = IDX_W'(CELL_INDEX);

    // Tag compares against the broadcast page and frame.
    assign page_match  = valid_reg && (page_reg == cmd.page);
    assign frame_match = valid_reg && (frame_reg == cmd.frame);
    assign insert_here = cmd.insert && (insert_idx == my_idx);
    assign evict_here  = cmd.evict && (victim_idx == my_idx);

    // Valid bit update; invalidation has priority over insertion.
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.flush) begin
            valid_next = 1'b0;
        end else if (cmd.purge && (page_match || frame_match)) begin
            valid_next = 1'b0;
        end else if (evict_here) begin
            valid_next = 1'b0;
        end else if (insert_here) begin
            valid_next = 1'b1;
        end
    end

    // Entry contents: written on insertion, use stamp refreshed on an LRU hit.
    always_comb
    begin
        page_next       = page_reg;
        frame_next      = frame_reg;
        fill_stamp_next = fill_stamp_reg;
        use_stamp_next  = use_stamp_reg;
        if (insert_here) begin
            page_next       = cmd.page;
            frame_next      = cmd.frame;
            fill_stamp_next = cmd.stamp;
            use_stamp_next  = cmd.stamp;
        end else if (cmd.touch && page_match) begin
            use_stamp_next  = cmd.stamp;
        end
    end

    // Ages are taken relative to the current stamp counter, modulo the stamp width.
    assign use_age  = cmd.stamp - use_stamp_reg;
    assign fill_age = cmd.stamp - fill_stamp_reg;
    assign age      = cmd.lru ? use_age : fill_age;

    // This entry replaces the incoming candidate only when strictly older, or equally old
    // but filled earlier, so lower slots win full ties.
    assign take_self = valid_reg &&
                       (!cand_in.found || (age > cand_in.age) ||
                        ((age == cand_in.age) && (fill_age > cand_in.fill_age)));

    always_comb
    begin
        if (take_self) begin
            cand_next.found    = 1'b1;
            cand_next.age      = age;
            cand_next.fill_age = fill_age;
            cand_idx_next      = my_idx;
        end else begin
            cand_next          = cand_in;
            cand_idx_next      = cand_idx_in;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            cand_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        frame_reg      <= frame_next;
        fill_stamp_reg <= fill_stamp_next;
        use_stamp_reg  <= use_stamp_next;
        cand_idx_reg   <= cand_idx_next;
    end

    assign cand_out     = cand_reg;
    assign cand_idx_out = cand_idx_reg;

    assign stat.valid = valid_reg;
    assign stat.hit   = page_match;
    assign stat.frame = frame_reg;

endmodule

`default_nettype wire

// File: src/tlbfl_ctrl.sv
// Sequencer for the TLB: request capture, stamp counter, eviction loop and result word.
// Depends on tlbfl_pkg and tlb_translate_fifo_lru_core_defines.svh.
`default_nettype none
`include "tlb_translate_fifo_lru_core_defines.svh"

module tlbfl_ctrl #(
    parameter int  TLB_DEPTH = tlbfl_pkg::TLB_DEPTH_DEFAULT,
    localparam int IDX_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  tlbfl_pkg::req_t       request,
    input  tlbfl_pkg::cfg_t       cfg,
    input  tlbfl_pkg::stat_t      stat [TLB_DEPTH],
    input  wire                   victim_found,
    output tlbfl_pkg::cmd_t       cmd,
    output logic [IDX_W-1:0]      insert_idx,
    output logic                  done,
    output tlbfl_pkg::res_t       result
);

    localparam int CNT_W = $clog2(TLB_DEPTH + 1);

    tlbfl_pkg::state_t                  state_reg, state_next;
    tlbfl_pkg::req_t                    req_reg, req_next;
    logic [tlbfl_pkg::STAMP_BITS-1:0]   stamp_reg, stamp_next;
    logic [IDX_W-1:0]                   sweep_cnt_reg, sweep_cnt_next;
    logic                               replaced_reg, replaced_next;
    logic                               done_reg, done_next;
    tlbfl_pkg::res_t                    result_reg, result_next;

    logic [tlbfl_pkg::SHIFT_BITS-1:0]   shift;
    logic [tlbfl_pkg::PAGE_BITS-1:0]    page;
    logic [CNT_W-1:0]                   cap;
    logic [CNT_W-1:0]                   count;
    logic [IDX_W-1:0]                   free_idx;
    logic [TLB_DEPTH-1:0]               hit_vec;
    logic                               any_hit;
    logic [tlbfl_pkg::FRAME_BITS-1:0]   hit_frame;
    logic                               sweep_last;

    // Effective page size and capacity.
    assign shift = tlbfl_pkg::sat_shift(cfg.page_size_log2);
    assign page  = tlbfl_pkg::page_of(req_reg.logical_address, shift);

    always_comb
    begin
        if (cfg.tlb_entries == '0) begin
            cap = CNT_W'(1);
        end else if (32'(cfg.tlb_entries) > 32'(TLB_DEPTH)) begin
            cap = CNT_W'(TLB_DEPTH);
        end else begin
            cap = CNT_W'(cfg.tlb_entries);
        end
    end

    // Occupancy, lowest free slot and the frame of the hitting entry.
    always_comb
    begin
        count     = '0;
        free_idx  = '0;
        hit_frame = '0;
        for (int i = 0; i < TLB_DEPTH; i++) begin
            count      = count + CNT_W'(stat[i].valid);
            hit_vec[i] = stat[i].hit;
            if (stat[i].hit) begin
                hit_frame = hit_frame | stat[i].frame;
            end
        end
        for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
            if (!stat[i].valid) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit    = |hit_vec;
    assign sweep_last = (sweep_cnt_reg == IDX_W'(TLB_DEPTH - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlbfl_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = tlbfl_pkg::ST_LOOKUP;
                end
            end
            tlbfl_pkg::ST_LOOKUP: begin
                if (req_reg.op == tlbfl_pkg::OP_FILL) begin
                    state_next = tlbfl_pkg::ST_COUNT;
                end else begin
                    state_next = tlbfl_pkg::ST_IDLE;
                end
            end
            tlbfl_pkg::ST_COUNT: begin
                if (count >= cap) begin
                    state_next = tlbfl_pkg::ST_SWEEP;
                end else begin
                    state_next = tlbfl_pkg::ST_INSERT;
                end
            end
            tlbfl_pkg::ST_SWEEP: begin
                if (sweep_last) begin
                    state_next = tlbfl_pkg::ST_EVICT;
                end
            end
            tlbfl_pkg::ST_EVICT: begin
                if (victim_found) begin
                    state_next = tlbfl_pkg::ST_COUNT;
                end else begin
                    state_next = tlbfl_pkg::ST_INSERT;
                end
            end
            tlbfl_pkg::ST_INSERT: begin
                state_next = tlbfl_pkg::ST_IDLE;
            end
            default: begin
                state_next = tlbfl_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the cells and updates of the datapath registers.
    always_comb
    begin
        cmd.flush      = 1'b0;
        cmd.purge      = 1'b0;
        cmd.touch      = 1'b0;
        cmd.insert     = 1'b0;
        cmd.evict      = 1'b0;
        cmd.lru        = (cfg.replacement_mode == tlbfl_pkg::MODE_LRU);
        cmd.stamp      = stamp_reg;
        cmd.page       = page;
        cmd.frame      = req_reg.frame;
        req_next       = req_reg;
        stamp_next     = stamp_reg;
        sweep_cnt_next = '0;
        replaced_next  = replaced_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        case (state_reg)
            tlbfl_pkg::ST_IDLE: begin
                if (start) begin
                    req_next      = request;
                    replaced_next = 1'b0;
                end
            end
            tlbfl_pkg::ST_LOOKUP: begin
                result_next = '0;
                case (req_reg.op)
                    tlbfl_pkg::OP_TRANSLATE: begin
                        done_next = 1'b1;
                        if (any_hit) begin
                            result_next.hit              = 1'b1;
                            result_next.physical_address =
                                tlbfl_pkg::phys_addr(hit_frame, req_reg.logical_address, shift);
                            if (cmd.lru) begin
                                cmd.touch  = 1'b1;
                                stamp_next = stamp_reg + tlbfl_pkg::STAMP_BITS'(1);
                            end
                        end
                    end
                    tlbfl_pkg::OP_FILL: begin
                        cmd.purge = 1'b1;
                    end
                    tlbfl_pkg::OP_FLUSH: begin
                        cmd.flush = 1'b1;
                        done_next = 1'b1;
                    end
                    default: begin
                        done_next = 1'b1;
                    end
                endcase
            end
            tlbfl_pkg::ST_SWEEP: begin
                sweep_cnt_next = sweep_cnt_reg + IDX_W'(1);
            end
            tlbfl_pkg::ST_EVICT: begin
                if (victim_found) begin
                    cmd.evict     = 1'b1;
                    replaced_next = 1'b1;
                end
            end
            tlbfl_pkg::ST_INSERT: begin
                cmd.insert                   = 1'b1;
                stamp_next                   = stamp_reg + tlbfl_pkg::STAMP_BITS'(1);
                done_next                    = 1'b1;
                result_next.hit              = 1'b0;
                result_next.physical_address =
                    tlbfl_pkg::phys_addr(req_reg.frame, req_reg.logical_address, shift);
                result_next.replaced         = replaced_reg;
            end
            default: begin
                sweep_cnt_next = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= tlbfl_pkg::ST_IDLE;
            stamp_reg     <= '0;
            sweep_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            stamp_reg     <= stamp_next;
            sweep_cnt_reg <= sweep_cnt_next;
            done_reg      <= done_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        replaced_reg <= replaced_next;
        result_reg   <= result_next;
    end

    assign busy       = (state_reg != tlbfl_pkg::ST_IDLE);
    assign insert_idx = free_idx;
    assign done       = done_reg;
    assign result     = result_reg;

    // No page is ever held by two valid entries.
    `TLBFL_ASSERT_IMPL(a_hit_unique, (state_reg == tlbfl_pkg::ST_LOOKUP) && (req_reg.op == tlbfl_pkg::OP_TRANSLATE), $onehot0(hit_vec), "two entries hit the same page")
    // A full sweep over an occupied TLB always yields a victim.
    `TLBFL_ASSERT_IMPL(a_victim_found, state_reg == tlbfl_pkg::ST_EVICT, victim_found, "eviction sweep found no victim")
    // Insertion only happens with a free slot below capacity.
    `TLBFL_ASSERT_IMPL(a_insert_room, state_reg == tlbfl_pkg::ST_INSERT, count < cap, "insert with the TLB at capacity")
    // An insertion ends the fill with a result strobe.
    `TLBFL_ASSERT_NEXT(a_insert_done, state_reg == tlbfl_pkg::ST_INSERT, done_reg && (state_reg == tlbfl_pkg::ST_IDLE), "fill finished without a result")

endmodule

`default_nettype wire

// File: src/tlb_translate_fifo_lru_core.sv
// Top level of the fully associative TLB: configuration registers, entry cells, sequencer.
// Depends on tlbfl_pkg, tlbfl_cell and tlbfl_ctrl.
`default_nettype none

// Fully associative TLB with FIFO or LRU replacement. A word is taken when start is
// high and busy is low; its result appears for exactly one cycle with done high and
// must be captured then, as the block cannot be stalled. Translate, flush and unknown
// operations keep busy high only while in the lookup state and present the result in
// the cycle after it; a new word may start in the cycle done is high. A fill goes
// through lookup, then count, sweep and evict once per entry it evicts, then insert:
// each eviction waits for the victim candidate to ripple through the row of
// TLB_DEPTH entry cells, one cell per cycle, between the count and evict states.
// Configuration writes take effect at once and are meant for when the block is idle.
module tlb_translate_fifo_lru_core #(
    parameter int TLB_DEPTH = tlbfl_pkg::TLB_DEPTH_DEFAULT
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      start,
    output logic                                     busy,
    input  tlbfl_pkg::req_t                          request,
    output logic                                     done,
    output tlbfl_pkg::res_t                          result,
    input  wire                                      cfg_wr_en,
    input  wire  [tlbfl_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire  [tlbfl_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

    localparam int IDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;

    tlbfl_pkg::cfg_t     cfg_reg, cfg_next;
    tlbfl_pkg::cmd_t     cmd;
    tlbfl_pkg::stat_t    stat [TLB_DEPTH];
    tlbfl_pkg::cand_t    chain [TLB_DEPTH+1];
    logic [IDX_W-1:0]    chain_idx [TLB_DEPTH+1];
    logic [IDX_W-1:0]    insert_idx;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                tlbfl_pkg::REG_PAGE_SIZE_LOG2: begin
                    cfg_next.page_size_log2 = cfg_wdata[tlbfl_pkg::SHIFT_BITS-1:0];
                end
                tlbfl_pkg::REG_REPLACEMENT_MODE: begin
                    cfg_next.replacement_mode = cfg_wdata[0];
                end
                tlbfl_pkg::REG_TLB_ENTRIES: begin
                    cfg_next.tlb_entries = cfg_wdata[tlbfl_pkg::ENTRIES_BITS-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.page_size_log2   <= tlbfl_pkg::PAGE_SIZE_LOG2_RST;
            cfg_reg.replacement_mode <= tlbfl_pkg::MODE_FIFO;
            cfg_reg.tlb_entries      <= tlbfl_pkg::TLB_ENTRIES_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The head of the victim chain carries no candidate.
    assign chain[0]     = '0;
    assign chain_idx[0] = '0;

    // Row of entry cells; each hands its best candidate so far to the next.
    for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_cell
        tlbfl_cell #(
            .TLB_DEPTH  (TLB_DEPTH),
            .CELL_INDEX (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .insert_idx   (insert_idx),
            .victim_idx   (chain_idx[TLB_DEPTH]),
            .cand_in      (chain[g]),
            .cand_idx_in  (chain_idx[g]),
            .cand_out     (chain[g+1]),
            .cand_idx_out (chain_idx[g+1]),
            .stat         (stat[g])
        );
    end

    // Sequencer.
    tlbfl_ctrl #(
        .TLB_DEPTH (TLB_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg          (cfg_reg),
        .stat         (stat),
        .victim_found (chain[TLB_DEPTH].found),
        .cmd          (cmd),
        .insert_idx   (insert_idx),
        .done         (done),
        .result       (result)
    );

endmodule

`default_nettype wire
